// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the packer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/tlzfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlzfp_pkg
// Types and constants shared by the two-level zero-flag packer.
// ----------------------------------------------------------------------------
package tlzfp_pkg;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_BFLAG = 2'd1;
    localparam logic [1:0] KIND_AFLAG = 2'd2;

    localparam logic [7:0] FLAG_TOP   = 8'h80;
    localparam logic [2:0] GROUP_MASK = 3'd7;
    localparam logic [3:0] GROUP_SIZE = 4'd8;

    // emit bit positions in a queued command
    localparam int EMIT_DATA  = 0;
    localparam int EMIT_BFLAG = 1;
    localparam int EMIT_AFLAG = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       run_last;
    } out_item_t;

    // one classified input byte: payloads plus which results it emits
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] b_flag;
        logic [7:0] a_flag;
        logic [2:0] emit;
    } cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hw/rtl/two_level_zero_flag_packer.sv =====
// ----------------------------------------------------------------------------
// two_level_zero_flag_packer
// Zero-byte suppression packer with byte (B) and group (A) flags.
// ----------------------------------------------------------------------------
// Feed bytes from the end of the stream toward its start, with stream_start
// on the first one; length_mod_64 is latched from the config channel and is
// read at that stream start. An input byte is accepted whenever the
// internal command queue (QUEUE_DEPTH entries) has room. Each byte yields
// zero to three results (data byte, B flag, A flag, in that order), and the
// back end drives one result per cycle into the output register while that
// register is empty or being popped. The queue lets the input take further
// bytes while earlier ones are still emitting results; the input stalls when
// the queue is full. Each result passes through the queue, the working
// command register and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_level_zero_flag_packer
    import tlzfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   in_item,
    output logic       empty,
    input  logic       pop,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data
);

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    cmd_t      q_wr_cmd;
    cmd_t      q_rd_cmd;

    assign cfg_ready = 1'b1;

    tlzfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_cmd     (q_wr_cmd)
    );

    tlzfp_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_cmd (q_wr_cmd),
        .rd_en  (q_pop),
        .rd_cmd (q_rd_cmd),
        .status (q_status)
    );

    tlzfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_cmd    (q_rd_cmd),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    `ASSERT_IMPLIES(a_queue_flags, clk, rst_n, q_status.full, !q_status.empty)
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, !q_status.empty)
    `ASSERT_IMPLIES(a_kind_legal, clk, rst_n, !empty, out_item.out_kind <= KIND_AFLAG)
    `ASSERT_IMPLIES(a_aflag_last, clk, rst_n, !empty && (out_item.out_kind == KIND_AFLAG), out_item.run_last)

endmodule

// ===== hw/rtl/tlzfp_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// tlzfp_cmd_queue
// Short FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module tlzfp_cmd_queue
    import tlzfp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  cmd_t      wr_cmd,
    input  logic      rd_en,
    output cmd_t      rd_cmd,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_wr;
    logic do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== hw/rtl/tlzfp_front.sv =====
// ----------------------------------------------------------------------------
// tlzfp_front
// Accepts input bytes, tracks group flags and counters, and queues one
// command per byte that yields results, describing those results.
// ----------------------------------------------------------------------------
module tlzfp_front
    import tlzfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    input  logic      cfg_valid,
    input  logic [5:0] cfg_data,
    input  q_status_t q_status,
    output logic      q_push,
    output cmd_t      q_cmd
);

    logic [5:0] len_reg;
    logic [7:0] bflag_reg, bflag_next;
    logic [7:0] aflag_reg, aflag_next;
    logic [3:0] bleft_reg, bleft_next;
    logic [3:0] gleft_reg, gleft_next;

    logic       accept;
    logic [7:0] bflag_cur;
    logic [7:0] aflag_cur;
    logic [3:0] bleft_cur;
    logic [3:0] gleft_cur;
    logic [2:0] b_load;
    logic [6:0] len_round;
    logic [2:0] a_load;
    logic       nz;
    logic [7:0] bflag_sh;
    logic [7:0] aflag_sh;
    logic       group_done;
    logic       block_done;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    assign b_load    = len_reg[2:0] & GROUP_MASK;
    assign len_round = {1'b0, len_reg} + 7'd7;
    assign a_load    = len_round[5:3] & GROUP_MASK;

    always_comb
    begin
        // a stream start reloads alignment before the byte is counted
        if (in_item.stream_start)
        begin
            bflag_cur = '0;
            aflag_cur = '0;
            bleft_cur = (b_load == '0) ? GROUP_SIZE : {1'b0, b_load};
            gleft_cur = (a_load == '0) ? GROUP_SIZE : {1'b0, a_load};
        end
        else
        begin
            bflag_cur = bflag_reg;
            aflag_cur = aflag_reg;
            bleft_cur = bleft_reg;
            gleft_cur = gleft_reg;
        end

        nz         = (in_item.data_byte != '0);
        bflag_sh   = {nz, bflag_cur[7:1]};
        aflag_sh   = {(bflag_sh != '0), aflag_cur[7:1]};
        group_done = (bleft_cur <= 4'd1) || (bleft_cur > GROUP_SIZE);
        block_done = (gleft_cur <= 4'd1) || (gleft_cur > GROUP_SIZE);

        q_cmd.data_byte        = in_item.data_byte;
        q_cmd.b_flag           = bflag_sh;
        q_cmd.a_flag           = aflag_sh;
        q_cmd.emit             = '0;
        q_cmd.emit[EMIT_DATA]  = nz;
        q_cmd.emit[EMIT_BFLAG] = group_done && (bflag_sh != '0);
        q_cmd.emit[EMIT_AFLAG] = group_done && block_done;

        if (group_done)
        begin
            bflag_next = '0;
            bleft_next = GROUP_SIZE;
            if (block_done)
            begin
                aflag_next = '0;
                gleft_next = GROUP_SIZE;
            end
            else
            begin
                aflag_next = aflag_sh;
                gleft_next = gleft_cur - 1'b1;
            end
        end
        else
        begin
            bflag_next = bflag_sh;
            bleft_next = bleft_cur - 1'b1;
            aflag_next = aflag_cur;
            gleft_next = gleft_cur;
        end
    end

    // a byte with no result still advances the state but queues nothing
    assign q_push = accept && (q_cmd.emit != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            bflag_reg <= '0;
            aflag_reg <= '0;
            bleft_reg <= GROUP_SIZE;
            gleft_reg <= GROUP_SIZE;
        end
        else
        begin
            if (cfg_valid)
            begin
                len_reg <= cfg_data;
            end
            if (accept)
            begin
                bflag_reg <= bflag_next;
                aflag_reg <= aflag_next;
                bleft_reg <= bleft_next;
                gleft_reg <= gleft_next;
            end
        end
    end

endmodule

// ===== hw/rtl/tlzfp_back.sv =====
// ----------------------------------------------------------------------------
// tlzfp_back
// Pulls commands from the queue and emits their results one per cycle
// through an output register, while that register is empty or popped.
// ----------------------------------------------------------------------------
module tlzfp_back
    import tlzfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    cmd_t       cur_reg, cur_next;
    logic [2:0] rem_reg, rem_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;

    logic       out_free;
    logic [2:0] sel;
    logic       take;
    logic [2:0] rem_after;
    logic [2:0] rem_left;

    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        sel = '0;
        if (rem_reg[EMIT_DATA])
        begin
            sel[EMIT_DATA] = 1'b1;
        end
        else if (rem_reg[EMIT_BFLAG])
        begin
            sel[EMIT_BFLAG] = 1'b1;
        end
        else if (rem_reg[EMIT_AFLAG])
        begin
            sel[EMIT_AFLAG] = 1'b1;
        end

        take      = out_free && (rem_reg != '0);
        rem_left  = rem_reg & ~sel;
        rem_after = take ? rem_left : rem_reg;

        // refill the working command as soon as its last result goes out
        q_pop    = (rem_after == '0) && !q_status.empty;
        rem_next = q_pop ? q_cmd.emit : rem_after;
        cur_next = q_pop ? q_cmd : cur_reg;

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (take)
        begin
            out_valid_next    = 1'b1;
            out_next.run_last = (rem_left == '0);
            if (sel[EMIT_DATA])
            begin
                out_next.out_byte = cur_reg.data_byte;
                out_next.out_kind = KIND_DATA;
            end
            else if (sel[EMIT_BFLAG])
            begin
                out_next.out_byte = cur_reg.b_flag;
                out_next.out_kind = KIND_BFLAG;
            end
            else
            begin
                out_next.out_byte = cur_reg.a_flag;
                out_next.out_kind = KIND_AFLAG;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level zero-flag packer.
// ----------------------------------------------------------------------------
// Byte streams are queued by the stimulus process and pushed by a clocked
// driver. At every accepted push transaction the packer's output is predicted
// in the bench: data byte, B flag and A flag. The predicted results are
// compared in order with the popped results. Both sides insert random idle
// bursts. One long pop hold-off fills the packer so that its input stalls.
// The length register is rewritten only while the packer is idle.
// ----------------------------------------------------------------------------
module tb;
    import tlzfp_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 270;
    localparam int BURST_ITEMS   = 16;
    localparam int TAIL_ITEMS    = 48;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    in_item_t   in_item = '0;
    logic       empty;
    logic       pop = 1'b0;
    out_item_t  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data = '0;

    // packer state as the bench sees it
    logic [7:0] b_flags = '0;
    logic [7:0] a_flags = '0;
    logic [3:0] bytes_left = GROUP_SIZE;
    logic [3:0] groups_left = GROUP_SIZE;
    logic [5:0] length_shadow = '0;

    in_item_t   pending_bytes[$];
    out_item_t  expected_results[$];
    out_item_t  want;

    int  errors = 0;
    int  items_queued = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_cnt = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_request = 1'b0;
    bit  hold_done = 1'b0;
    logic holding;

    assign holding = hold_request && !hold_done;

    two_level_zero_flag_packer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Expected results for one accepted byte
    task automatic pack_byte(input in_item_t it);
        out_item_t  res[3];
        int         n;
        logic [2:0] lo;
        logic [6:0] sum;
        n = 0;
        if (it.stream_start)
        begin
            lo  = length_shadow[2:0] & GROUP_MASK;
            sum = {1'b0, length_shadow} + 7'd7;
            bytes_left  = (lo == 3'd0) ? GROUP_SIZE : {1'b0, lo};
            groups_left = (sum[5:3] == 3'd0) ? GROUP_SIZE : {1'b0, sum[5:3]};
            b_flags = '0;
            a_flags = '0;
        end
        b_flags = b_flags >> 1;
        if (it.data_byte != 8'd0)
        begin
            res[n] = '{out_byte: it.data_byte, out_kind: KIND_DATA, run_last: 1'b0};
            n++;
            b_flags = b_flags | FLAG_TOP;
        end
        if (bytes_left <= 4'd1 || bytes_left > GROUP_SIZE)
        begin
            bytes_left = GROUP_SIZE;
            a_flags = a_flags >> 1;
            if (b_flags != 8'd0)
            begin
                res[n] = '{out_byte: b_flags, out_kind: KIND_BFLAG, run_last: 1'b0};
                n++;
                a_flags = a_flags | FLAG_TOP;
            end
            b_flags = '0;
            if (groups_left <= 4'd1 || groups_left > GROUP_SIZE)
            begin
                groups_left = GROUP_SIZE;
                res[n] = '{out_byte: a_flags, out_kind: KIND_AFLAG, run_last: 1'b0};
                n++;
                a_flags = '0;
            end
            else
            begin
                groups_left = groups_left - 4'd1;
            end
        end
        else
        begin
            bytes_left = bytes_left - 4'd1;
        end
        if (n > 0)
            res[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.insert(expected_results.size(), res[i]);
    endtask

    // Push side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                pack_byte(pending_bytes.pop_front());
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                push <= 1'b0;
            end
            else if (pending_bytes.size() == 0)
            begin
                push <= 1'b0;
            end
            else if (!quiet && !holding && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(1, 5) - 1;
                push <= 1'b0;
            end
            else
            begin
                push    <= 1'b1;
                in_item <= pending_bytes[0];
            end
        end
    end

    // Pop side and result check
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: out_byte=%h out_kind=%0d run_last=%0b",
                           out_item.out_byte, out_item.out_kind, out_item.run_last);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_item.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, out_item.out_byte);
                        errors++;
                    end
                    if (out_item.out_kind !== want.out_kind)
                    begin
                        $error("out_kind: expected %0d, actual %0d",
                               want.out_kind, out_item.out_kind);
                        errors++;
                    end
                    if (out_item.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, actual %0b",
                               want.run_last, out_item.run_last);
                        errors++;
                    end
                end
            end
            if (holding)
            begin
                // long hold-off so the packer backs up into its input
                pop <= 1'b0;
                hold_cnt = hold_cnt + 1;
                if (hold_cnt >= HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                pop <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                recv_gap = $urandom_range(1, 5) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_byte(input int zero_pct);
        if ($urandom_range(0, 99) < zero_pct)
            return 8'h00;
        if ($urandom_range(0, 7) == 0)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_byte(input logic [7:0] d, input logic start);
        in_item_t it;
        it = '{data_byte: d, stream_start: start};
        pending_bytes.insert(pending_bytes.size(), it);
        items_queued++;
    endtask

    task automatic write_length(input logic [5:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        length_shadow = v;
    endtask

    // drain everything, then let zero-result bytes clear the pipe
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_stream(input int len);
        int zero_pct;
        zero_pct = ($urandom_range(0, 1) == 0) ? 30 : 85;
        // occasionally cut the stream short
        if ($urandom_range(0, 5) == 0)
            len = $urandom_range(1, len);
        for (int i = 0; i < len; i++)
            add_byte(rand_byte(zero_pct), i == 0);
    endtask

    initial
    begin
        int          phase;
        int          len_cfg;
        int          len;
        int          streams;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset alignment, no stream start
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        wait_idle();

        // length 1: each start byte closes both groups
        write_length(6'd1);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        wait_idle();

        // new length only takes effect at the next start; restart mid-stream
        write_length(6'd63);
        add_byte(8'h55, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h01, 1'b1);
        wait_idle();

        write_length(6'd0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        wait_idle();

        phase = 0;
        while (items_queued < RANDOM_ITEMS)
        begin
            if (phase == 0)
                len_cfg = 0;
            else if (phase == 1)
                len_cfg = 63;
            else
                len_cfg = $urandom_range(0, 63);
            write_length(6'(len_cfg));
            if (phase == 0)
            begin
                hold_request = 1'b1;
                // dense burst so the queue fills during the hold-off
                for (int k = 0; k < BURST_ITEMS; k++)
                    add_byte(rand_byte(0), k == 0);
            end
            streams = $urandom_range(1, 3);
            for (int s = 0; s < streams; s++)
            begin
                if (items_queued >= RANDOM_ITEMS)
                    break;
                len = len_cfg + 64 * $urandom_range(0, 1);
                if (len == 0)
                    len = 64;
                add_stream(len);
                if ($urandom_range(0, 7) == 0)
                begin
                    // stray bytes with random start marks
                    for (int k = $urandom_range(1, 6); k > 0; k--)
                        add_byte(rand_byte(40), 1'($urandom_range(0, 1)));
                end
            end
            wait_idle();
            phase++;
        end

        // closing stream with no idle bursts on either side
        quiet = 1'b1;
        write_length(6'(TAIL_ITEMS));
        for (int i = 0; i < TAIL_ITEMS; i++)
            add_byte(rand_byte(30), i == 0);
        wait_idle();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
